// ----- sv/fir_filter_41_tap_macros.svh -----
// Assertion macros shared by the fir_filter_41_tap RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef FIR_FILTER_41_TAP_MACROS_SVH
`define FIR_FILTER_41_TAP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FIR41_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define FIR41_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define FIR41_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fir41_pkg.sv -----
// Package for the fir_filter_41_tap block: widths, coefficient table and
// the command and status types between controller and datapath. No dependencies.
`default_nettype none

package fir41_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int TAPS           = 41;
    localparam int TAP_W          = $clog2(TAPS);
    localparam int COEF_FRAC_BITS = 15;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int ACC_W          = PROD_W + TAP_W;
    localparam int OUT_MAX        = 2 ** (SAMPLE_W - 1) - 1;
    localparam int OUT_MIN        = -(2 ** (SAMPLE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic [TAP_W-1:0]           tap_idx_t;

    localparam tap_idx_t LAST_TAP = tap_idx_t'(TAPS - 1);

    // Symmetric high-pass design, rounded to signed Q1.15.
    localparam coef_t COEF_Q15 [TAPS] = '{
        16'sd575,   16'sd759,   16'sd936,   16'sd1092,  16'sd1213,
        16'sd1286,  16'sd1301,  16'sd1249,  16'sd1126,  16'sd933,
        16'sd674,   16'sd358,   16'sd0,     -16'sd384,  -16'sd775,
        -16'sd1152, -16'sd1494, -16'sd1783, -16'sd2001, -16'sd2138,
        16'sd30583,
        -16'sd2138, -16'sd2001, -16'sd1783, -16'sd1494, -16'sd1152,
        -16'sd775,  -16'sd384,  16'sd0,     16'sd358,   16'sd674,
        16'sd933,   16'sd1126,  16'sd1249,  16'sd1301,  16'sd1286,
        16'sd1213,  16'sd1092,  16'sd936,   16'sd759,   16'sd575
    };

    function automatic coef_t tap_coef(input tap_idx_t idx);
        coef_t c;
        if (idx <= LAST_TAP)
        begin
            c = COEF_Q15[idx];
        end
        else
        begin
            c = '0;
        end
        return c;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;    // take the sample, write the delay line, clear the sum
        logic     issue;   // read one tap of the delay line
        tap_idx_t tap;     // coefficient index for the tap being read
        logic     finish;  // round, saturate and load the output register
    } fir41_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;   // products still on their way into the accumulator
        logic out_free;    // the output register can take a new result
    } fir41_status_t;

endpackage

`default_nettype wire

// ----- sv/fir41_if.sv -----
// Valid/ready channel interfaces for the sample input and the filtered output.
// Depends on fir41_pkg.
`default_nettype none

interface fir41_in_if import fir41_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir41_out_if import fir41_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ----- sv/fir41_ctrl.sv -----
// Sequencing controller for the FIR filter: accepts a sample, steps through
// the taps and closes the sum. Depends on fir41_pkg.
`default_nettype none

module fir41_ctrl import fir41_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output fir41_cmd_t   cmd,
    input  wire fir41_status_t status
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    tap_idx_t   tap_reg;
    tap_idx_t   tap_next;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.tap    = tap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    tap_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/fir41_datapath.sv -----
// Datapath of the FIR filter: delay-line memory, multiply-accumulate pipeline,
// rounding and saturation, output register. Depends on fir41_pkg, fir41_if, macros.
`default_nettype none
`include "fir_filter_41_tap_macros.svh"

module fir41_datapath import fir41_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sample_t   sample_in,
    input  wire fir41_cmd_t cmd,
    output fir41_status_t  status,
    fir41_out_if.source    out_chan
);

    // Delay line: one write port, one registered read port.
    sample_t           mem [TAPS];
    logic [TAPS-1:0]   filled_reg;
    tap_idx_t          pos_reg;
    tap_idx_t          pos_next;
    tap_idx_t          rd_addr_reg;
    tap_idx_t          rd_addr_next;

    // Read stage.
    logic              s1_valid_reg;
    sample_t           rd_data_reg;
    logic              rd_filled_reg;
    coef_t             s1_coef_reg;
    sample_t           s1_sample;

    // Product stage and accumulator.
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // Rounding and output.
    logic signed [ACC_W-1:0]   bias;
    logic signed [ACC_W-1:0]   biased;
    logic signed [ACC_W-1:0]   shifted;
    sample_t                   result;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    sample_t                   out_data_reg;

    assign pos_next     = (pos_reg == LAST_TAP) ? '0 : pos_reg + 1'b1;
    assign rd_addr_next = (rd_addr_reg == '0) ? LAST_TAP : rd_addr_reg - 1'b1;
    assign s1_sample    = rd_filled_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[pos_reg] <= sample_in;
        end
        if (cmd.issue)
        begin
            rd_data_reg   <= mem[rd_addr_reg];
            rd_filled_reg <= filled_reg[rd_addr_reg];
            s1_coef_reg   <= tap_coef(cmd.tap);
        end
        if (s1_valid_reg)
        begin
            prod_reg <= s1_sample * s1_coef_reg;
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.finish)
        begin
            out_data_reg <= result;
        end
    end

    // Truncation toward zero: a negative sum is biased by one less than the
    // divisor before the arithmetic shift.
    always_comb
    begin
        bias    = '0;
        bias[COEF_FRAC_BITS-1:0] = {COEF_FRAC_BITS{acc_reg[ACC_W-1]}};
        biased  = acc_reg + bias;
        shifted = biased >>> COEF_FRAC_BITS;
        if (shifted > ACC_W'(OUT_MAX))
        begin
            result = sample_t'(OUT_MAX);
        end
        else if (shifted < ACC_W'(OUT_MIN))
        begin
            result = sample_t'(OUT_MIN);
        end
        else
        begin
            result = shifted[SAMPLE_W-1:0];
        end
    end

    assign out_valid_next = cmd.finish ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            pos_reg       <= '0;
            rd_addr_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                filled_reg[pos_reg] <= 1'b1;
                pos_reg             <= pos_next;
                rd_addr_reg         <= pos_reg;
            end
            else if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_next;
            end
            s1_valid_reg  <= cmd.issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.pipe_busy  = s1_valid_reg | s2_valid_reg;
    assign status.out_free   = !out_valid_reg || out_chan.ready;
    assign out_chan.valid      = out_valid_reg;
    assign out_chan.sample_out = out_data_reg;

    `FIR41_ASSERT_ALWAYS(a_pos_range, pos_reg <= LAST_TAP, "write address out of range")
    `FIR41_ASSERT_ALWAYS(a_rd_range, rd_addr_reg <= LAST_TAP, "read address out of range")
    `FIR41_ASSERT_IMPLY(a_finish_drained, cmd.finish, !status.pipe_busy, "sum closed early")
    `FIR41_ASSERT_IMPLY(a_no_overwrite, cmd.finish, !out_valid_reg || out_chan.ready, "lost result")
    `FIR41_ASSERT_IMPLY(a_load_idle, cmd.load, !status.pipe_busy && !cmd.issue, "load while busy")

endmodule

`default_nettype wire

// ----- sv/fir_filter_41_tap.sv -----
// Top level of the 41-tap direct-form FIR filter.
// Depends on fir41_pkg, fir41_if, fir41_ctrl and fir41_datapath.
`default_nettype none

// fir_filter_41_tap filters signed 16-bit audio samples with a fixed,
// symmetric 41-tap high-pass design held as signed Q1.15 coefficients. Each
// input transaction carries one sample; it is written into a 41-entry circular
// delay line and exactly one output transaction follows, carrying the sum of
// the coefficients times that sample and the 40 before it, divided by 2^15
// with truncation toward zero and saturated to the signed 16-bit range. The
// delay line reads as zero after reset, so the first outputs see silence in
// the older taps. One sample is worked at a time. The delay line is written
// at the accepting edge; then the single read port of the delay-line memory
// delivers the taps one at a time to the shared multiply-accumulate unit,
// the read, multiply and accumulate stages empty, and the sum is rounded into
// the output register. The input is ready again in the cycle after the result
// is registered, so a new sample is only accepted once the previous result
// has reached the output register. A result waiting in the output register
// does not stop the next sample from being accepted; only the closing of the
// following sum waits until that result has been taken.

module fir_filter_41_tap import fir41_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fir41_in_if.sink    in_chan,
    fir41_out_if.source out_chan
);

    fir41_cmd_t    cmd;
    fir41_status_t status;
    logic          in_ready;

    // The controller sequences the load, the 41 tap reads and the final
    // rounding; it sees the datapath only through the command and status
    // structures.
    fir41_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath owns the delay-line memory, the multiply-accumulate
    // pipeline and the output register that drives the output channel.
    fir41_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (in_chan.sample_in),
        .cmd       (cmd),
        .status    (status),
        .out_chan  (out_chan)
    );

    assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 41-tap high-pass FIR filter, fir_filter_41_tap.
// Depends on fir41_pkg, the channel interfaces in fir41_if and the RTL of the filter.

module testbench;
    import fir41_pkg::*;

    // Timing of the bench and of the block.
    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int SAMPLE_LATENCY   = 44;    // acceptance to registered result
    localparam int HOLD_OFF_CYCLES  = 400;   // long output stall in the pressure test
    localparam int STALL_LIMIT      = 5000;  // cycles without any transaction
    localparam int MAX_PRINTED      = 40;

    // The filter as the block should compute it: a symmetric high-pass design in
    // signed Q1.15, a wide sum, division by 2^15 towards zero and saturation.
    localparam int N_TAPS    = 41;
    localparam int FRAC_BITS = 15;
    localparam longint SAT_HIGH = 32767;
    localparam longint SAT_LOW  = -32768;
    localparam int HP_COEF [N_TAPS] = '{
        575, 759, 936, 1092, 1213, 1286, 1301, 1249, 1126, 933,
        674, 358, 0, -384, -775, -1152, -1494, -1783, -2001, -2138,
        30583,
        -2138, -2001, -1783, -1494, -1152, -775, -384, 0, 358, 674,
        933, 1126, 1249, 1301, 1286, 1213, 1092, 936, 759, 575
    };

    // Kinds of random sample. A matched burst lines the signs of a run of samples
    // up with the coefficient signs, which is what drives the sum into saturation.
    typedef enum int {
        KIND_FULL_RANGE,
        KIND_NEAR_ZERO,
        KIND_EXTREME,
        KIND_MATCHED_BURST
    } sample_kind_e;

    logic clk;
    logic rst_n;

    fir41_in_if  in_if ();
    fir41_out_if out_if ();

    fir_filter_41_tap u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_if),
        .out_chan (out_if)
    );

    // Filter state as the bench sees it: the delay line and the slot that
    // receives the next sample. Both read as zero after reset.
    sample_t sample_history [N_TAPS];
    int      history_slot;

    // Filtered samples that the block still owes, oldest first.
    sample_t expected_samples [$];

    // Idle percentages of the two sides, set by each test in turn.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // The long output hold-off is run by a process of its own.
    event hold_off_req;
    bit   holding_output;

    int error_count;
    int samples_sent;
    int results_taken;
    int saturated_high;
    int saturated_low;
    int stall_cycles;
    sample_t oldest_expected;

    // The clock starts high and has a 12 ns period.
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Every mismatch, stray result or leftover expectation comes through here. The
    // count is always kept, but printing stops after a while so that a badly
    // broken block does not flood the log.
    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Writes one sample into the delay line and returns the filtered output that
    // the block must produce for it. Negative sums are divided as magnitudes, so
    // the result truncates towards zero rather than towards minus infinity.
    function automatic sample_t filter_sample(input sample_t x);
        longint acc;
        longint scaled;
        int     idx;
        acc = 0;
        sample_history[history_slot] = x;
        for (int i = 0; i < N_TAPS; i++)
        begin
            idx = (history_slot + N_TAPS - i) % N_TAPS;
            acc += longint'(HP_COEF[i]) * longint'(sample_history[idx]);
        end
        if (acc < 0)
        begin
            scaled = -((-acc) >>> FRAC_BITS);
        end
        else
        begin
            scaled = acc >>> FRAC_BITS;
        end
        if (scaled > SAT_HIGH)
        begin
            scaled = SAT_HIGH;
            saturated_high++;
        end
        else if (scaled < SAT_LOW)
        begin
            scaled = SAT_LOW;
            saturated_low++;
        end
        history_slot = (history_slot + 1) % N_TAPS;
        return sample_t'(scaled);
    endfunction

    // A sample whose sign follows the coefficient of the given tap, so that its
    // product adds to the sum; flipped when the whole burst is to go negative.
    // Taps with a zero coefficient get a random sample, since they add nothing.
    function automatic sample_t matched_sample(input int tap, input int magnitude,
                                               input bit negative);
        longint v;
        if (HP_COEF[tap] == 0)
        begin
            return sample_t'($urandom_range(65535, 0));
        end
        v = (HP_COEF[tap] > 0) ? magnitude : -magnitude;
        if (negative)
        begin
            v = -v;
        end
        if (v > SAT_HIGH)
        begin
            v = SAT_HIGH;
        end
        return sample_t'(v);
    endfunction

    // Offers one sample, possibly after a short idle gap, and holds it until the
    // block takes it. The expected output is worked out at the moment of
    // acceptance, so the prediction follows exactly the order the block sees.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            gap = $urandom_range(6, 1);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= s;
        @(posedge clk);
        while (!in_if.ready)
        begin
            @(posedge clk);
        end
        expected_samples.push_back(filter_sample(s));
        samples_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_if.valid <= 1'b0;
    endtask

    // Lowers valid and waits until every output the block owes has been taken.
    // Should the block lose a result, the watchdog ends the run.
    task automatic wait_for_drain();
        stop_sending();
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Directed part. Straight out of reset the older taps hold zeros, so the
    // first 21 samples fill taps 20 down to 0 with full-scale values whose signs
    // match the coefficients: the partial sum already exceeds full scale and the
    // output must clip to the positive limit. Both input extremes appear here.
    // A few small samples follow, where negative sums must round towards zero.
    task automatic test_directed();
        sample_t s;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k <= N_TAPS / 2; k++)
        begin
            if (HP_COEF[N_TAPS / 2 - k] > 0)
            begin
                s = sample_t'(SAT_HIGH);
            end
            else if (HP_COEF[N_TAPS / 2 - k] < 0)
            begin
                s = sample_t'(SAT_LOW);
            end
            else
            begin
                s = '0;
            end
            send_sample(s);
        end
        send_sample(sample_t'(-1));
        send_sample(sample_t'(1));
        send_sample('0);
        send_sample(sample_t'(SAT_LOW));
        wait_for_drain();
    endtask

    // Random part for one idling pattern. Roughly a fifth of the draws are
    // coefficient-matched bursts of random length and polarity, which push the
    // sum into saturation either way; bursts shorter than the delay line leave
    // older, unrelated samples in the far taps and so land near the limit.
    // The rest are full-range samples, values close to zero and extremes.
    task automatic run_random_phase(input int item_count, input int unsigned snd_idle,
                                    input int unsigned rcv_idle);
        int           sent;
        int           burst_len;
        int           magnitude;
        bit           negative;
        sample_kind_e kind;
        int unsigned  pick;
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        sent = 0;
        while (sent < item_count)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 2)
            begin
                kind = KIND_MATCHED_BURST;
            end
            else if (pick == 2)
            begin
                kind = KIND_NEAR_ZERO;
            end
            else if (pick == 3)
            begin
                kind = KIND_EXTREME;
            end
            else
            begin
                kind = KIND_FULL_RANGE;
            end
            case (kind)
                KIND_MATCHED_BURST:
                begin
                    burst_len = $urandom_range(N_TAPS, 10);
                    magnitude = $urandom_range(32768, 12000);
                    negative  = $urandom_range(1, 0);
                    for (int k = 0; k < burst_len; k++)
                    begin
                        send_sample(matched_sample(burst_len - 1 - k, magnitude, negative));
                    end
                    sent += burst_len;
                end
                KIND_NEAR_ZERO:
                begin
                    send_sample(sample_t'(int'($urandom_range(16, 0)) - 8));
                    sent++;
                end
                KIND_EXTREME:
                begin
                    send_sample($urandom_range(1, 0) ? sample_t'(SAT_HIGH)
                                                     : sample_t'(SAT_LOW));
                    sent++;
                end
                default:
                begin
                    send_sample(sample_t'($urandom_range(65535, 0)));
                    sent++;
                end
            endcase
        end
        wait_for_drain();
    endtask

    // The output side stops taking results for a long stretch while samples keep
    // coming. One result sits in the output register, the next sample is still
    // accepted, and then the input must stall until the output moves again.
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        -> hold_off_req;
        for (int k = 0; k < 8; k++)
        begin
            send_sample(sample_t'($urandom_range(65535, 0)));
        end
        wait_for_drain();
    endtask

    // The input goes quiet until every result has come back, then resumes: the
    // filter history must carry over the pause untouched.
    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 5; k++)
        begin
            send_sample(sample_t'($urandom_range(65535, 0)));
        end
        wait_for_drain();
        for (int k = 0; k < 5; k++)
        begin
            send_sample(sample_t'($urandom_range(65535, 0)));
        end
        wait_for_drain();
    endtask

    // Output ready: random according to the current pattern, held low while a
    // long hold-off is running.
    always @(negedge clk)
    begin
        if (holding_output)
        begin
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Counts out the long hold-off on its own, in rising edges, so that the
    // flag never changes at the falling edge where ready is driven.
    always
    begin
        @(hold_off_req);
        holding_output = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holding_output = 1'b0;
    end

    // Every output transaction is compared with the oldest outstanding sample.
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            results_taken++;
            if (expected_samples.size() == 0)
            begin
                report_error($sformatf("output transaction %0d (sample_out %0d) with none outstanding",
                                       results_taken, out_if.sample_out));
            end
            else
            begin
                oldest_expected = expected_samples.pop_front();
                if (out_if.sample_out !== oldest_expected)
                begin
                    report_error($sformatf("output transaction %0d: sample_out %0d, expected %0d",
                                           results_taken, out_if.sample_out, oldest_expected));
                end
            end
        end
    end

    // Watchdog: the run ends if neither side completes a transaction for too
    // long. The longest legitimate quiet spell is the output hold-off plus one
    // sample's latency, well inside the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] ERROR: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.sample_in = '0;
        out_if.ready    = 1'b0;
        holding_output  = 1'b0;
        history_slot    = 0;
        error_count     = 0;
        samples_sent    = 0;
        results_taken   = 0;
        saturated_high  = 0;
        saturated_low   = 0;
        stall_cycles    = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        for (int i = 0; i < N_TAPS; i++)
        begin
            sample_history[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        run_random_phase(580, 18, 87);
        run_random_phase(580, 87, 18);
        test_output_hold_off();
        test_drain_pause();
        run_random_phase(560, 0, 0);

        // Everything has been accepted and drained; give a stray extra result
        // time to show up before the final verdict.
        repeat (2 * SAMPLE_LATENCY) @(posedge clk);
        if (expected_samples.size() != 0)
        begin
            report_error($sformatf("%0d filtered samples never arrived",
                                   expected_samples.size()));
        end

        $display("Filtered %0d samples and checked %0d outputs under three idling patterns,",
                 samples_sent, results_taken);
        $display("a long output stall and a drain pause; %0d outputs clipped high, %0d low.",
                 saturated_high, saturated_low);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
